// File: rtl/core/chdt_pkg.sv
package chdt_pkg;

    localparam int C_CNT_W  = 21;
    localparam int C_OFF_W  = 20;
    localparam int C_DIV_W  = 22;
    localparam int C_HASH_W = 64;

    localparam logic [C_HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    typedef logic [1:0] t_opcode;

    localparam t_opcode OP_BEGIN = 2'd0;
    localparam t_opcode OP_DATA  = 2'd1;
    localparam t_opcode OP_INVAL = 2'd2;

    typedef struct packed {
        t_opcode              opcode;
        logic [7:0]           data_byte;
        logic [C_CNT_W-1:0]   byte_count;
        logic [C_OFF_W-1:0]   byte_offset;
    } t_in_item;

    typedef struct packed {
        logic [7:0]           chunk_index;
        logic                 chunk_dirty;
        logic [C_HASH_W-1:0]  chunk_hash;
        logic                 final_chunk;
    } t_out_item;

    typedef struct packed {
        logic                 valid;
        logic [C_HASH_W-1:0]  hash;
    } t_entry;

    typedef struct packed {
        logic                 start;
        logic [C_DIV_W-1:0]   dividend;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [C_DIV_W-1:0]   quotient;
    } t_div_rsp;

    // One FNV-1a byte step; the 64-bit prime 2^40 + 0x1b3 is applied as shift-add.
    function automatic logic [C_HASH_W-1:0] fnv_step(input logic [C_HASH_W-1:0] h,
                                                     input logic [7:0] d);
        logic [C_HASH_W-1:0] x;
        x = h ^ {56'd0, d};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// File: rtl/core/chdt_stream_if.sv
interface chdt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/chdt_div.sv
module chdt_div #(
    parameter int CHUNK_BYTES = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  chdt_pkg::t_div_req  i_req,
    output chdt_pkg::t_div_rsp  o_rsp
);
    import chdt_pkg::*;

    localparam int SH = $clog2(CHUNK_BYTES);

    logic               r_done;
    logic [C_DIV_W-1:0] r_quo;

    // Chunk size is a power of two: the quotient is a registered right shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend >> SH;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// File: rtl/core/chdt_table.sv
module chdt_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output chdt_pkg::t_entry  o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  chdt_pkg::t_entry  i_wr_data
);
    import chdt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

// File: rtl/core/chunk_hash_dirty_tracker.sv
// Channel  | Dir | Payload                                         | Accepted when
// i_in     | in  | opcode, data_byte, byte_count, byte_offset      | valid && ready
// o_out    | out | chunk_index, chunk_dirty, chunk_hash, final_chunk| valid && ready
// i_cfg    | in  | invalidate_on_update (1 bit)                    | valid && ready
//
// A data byte that does not end a chunk is taken in the idle state; one that ends a
// chunk reads the table, then compares and writes back through the output register.
// A begin finds the chunk count by shift and, when the count changes, clears every chunk
// of the old count; an enabled invalidate of nonzero length runs two shift divides and
// clears each stored chunk it covers; other items stay idle. CHUNK_BYTES is a power of two.
// After reset the table is swept over all MAX_CHUNKS entries before the first item.
// A stalled output holds only the chunk-end compare, but no item is taken while it holds.
module chunk_hash_dirty_tracker #(
    parameter int CHUNK_BYTES = 4096,
    parameter int MAX_CHUNKS  = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    chdt_stream_if.sink   i_in,
    chdt_stream_if.source o_out,
    chdt_stream_if.sink   i_cfg
);
    import chdt_pkg::*;

    localparam int CIW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNTW = $clog2(MAX_CHUNKS + 1);
    localparam int CBW  = $clog2(CHUNK_BYTES);

    localparam logic [63:0]        LIMIT  = 64'(MAX_CHUNKS) * 64'(CHUNK_BYTES);
    localparam logic [C_DIV_W-1:0] CB_M1  = C_DIV_W'(CHUNK_BYTES - 1);
    localparam logic [CBW-1:0]     CIB_M1 = CBW'(CHUNK_BYTES - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BDIV  = 3'd1;
    localparam logic [2:0] S_IDIV1 = 3'd2;
    localparam logic [2:0] S_IDIV2 = 3'd3;
    localparam logic [2:0] S_SWP   = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;

    // Control and sequencing state
    logic [2:0]          r_state,    n_state;
    logic                r_inv_en;
    logic [C_CNT_W-1:0]  r_pos,      n_pos;
    logic [C_CNT_W-1:0]  r_size,     n_size;
    logic [CNTW-1:0]     r_stored,   n_stored;
    logic [CBW-1:0]      r_cib,      n_cib;
    logic [CIW-1:0]      r_cidx,     n_cidx;
    logic [C_DIV_W-1:0]  r_sweep,    n_sweep;
    logic [C_DIV_W-1:0]  r_end,      n_end;
    logic                r_out_valid, n_out_valid;

    // Payload
    logic [C_HASH_W-1:0] r_hash,     n_hash;
    logic [CIW-1:0]      r_end_idx,  n_end_idx;
    logic                r_end_last, n_end_last;
    logic [C_DIV_W-1:0]  r_dvd2,     n_dvd2;
    t_out_item           r_out,      n_out;

    // Table and divider connections
    logic                w_rd_en;
    logic [CIW-1:0]      w_rd_addr;
    t_entry              w_rd_data;
    logic                w_wr_en;
    logic [CIW-1:0]      w_wr_addr;
    t_entry              w_wr_data;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    logic [C_CNT_W-1:0]  w_size;
    logic [C_CNT_W-1:0]  w_pos_inc;
    logic                w_last;
    logic [C_HASH_W-1:0] w_prev;
    logic                w_dirty;
    logic [C_DIV_W-1:0]  w_stored_ext;
    logic [C_DIV_W-1:0]  w_q_inc;

    chdt_table #(.DEPTH(MAX_CHUNKS), .AW(CIW)) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    chdt_div #(.CHUNK_BYTES(CHUNK_BYTES)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        // Saturate the upload to the table's reach
        w_size       = (64'(i_in.data.byte_count) > LIMIT) ? LIMIT[C_CNT_W-1:0]
                                                           : i_in.data.byte_count;
        w_pos_inc    = r_pos + 1'b1;
        w_last       = (w_pos_inc == r_size);
        w_prev       = w_rd_data.valid ? w_rd_data.hash : '0;
        w_dirty      = (r_hash != w_prev);
        w_stored_ext = C_DIV_W'(r_stored);
        w_q_inc      = w_div_rsp.quotient + 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_size      = r_size;
        n_stored    = r_stored;
        n_cib       = r_cib;
        n_cidx      = r_cidx;
        n_sweep     = r_sweep;
        n_end       = r_end;
        n_out_valid = r_out_valid;
        n_hash      = r_hash;
        n_end_idx   = r_end_idx;
        n_end_last  = r_end_last;
        n_dvd2      = r_dvd2;
        n_out       = r_out;

        w_rd_en     = 1'b0;
        w_rd_addr   = r_cidx;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_sweep[CIW-1:0];
        w_wr_data   = '0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_dvd2;

        // Drop the result once the sink takes it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    unique case (i_in.data.opcode)
                        OP_BEGIN: begin
                            n_size  = w_size;
                            n_pos   = '0;
                            n_hash  = FNV_BASIS;
                            n_cib   = '0;
                            n_cidx  = '0;
                            w_div_req.start    = 1'b1;
                            w_div_req.dividend = C_DIV_W'(w_size) + CB_M1;
                            n_state = S_BDIV;
                        end
                        OP_DATA: begin
                            if (r_pos < r_size) begin
                                n_hash = fnv_step(r_hash, i_in.data.data_byte);
                                n_pos  = w_pos_inc;
                                if (w_last || (r_cib == CIB_M1)) begin
                                    // Chunk ends: fetch the stored hash
                                    n_cib      = '0;
                                    n_cidx     = r_cidx + 1'b1;
                                    w_rd_en    = 1'b1;
                                    n_end_idx  = r_cidx;
                                    n_end_last = w_last;
                                    n_state    = S_CMP;
                                end else begin
                                    n_cib = r_cib + 1'b1;
                                end
                            end
                        end
                        OP_INVAL: begin
                            if (r_inv_en && (i_in.data.byte_count != '0)) begin
                                n_dvd2 = C_DIV_W'(i_in.data.byte_offset)
                                       + C_DIV_W'(i_in.data.byte_count) - 1'b1;
                                w_div_req.start    = 1'b1;
                                w_div_req.dividend = C_DIV_W'(i_in.data.byte_offset);
                                n_state = S_IDIV1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_BDIV: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quotient != w_stored_ext) begin
                        // Count changed: clear every entry of the old count
                        n_stored = CNTW'(w_div_rsp.quotient);
                        n_sweep  = '0;
                        n_end    = w_stored_ext;
                        n_state  = S_SWP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDIV1: begin
                if (w_div_rsp.done) begin
                    n_sweep         = w_div_rsp.quotient;
                    w_div_req.start = 1'b1;
                    n_state         = S_IDIV2;
                end
            end
            S_IDIV2: begin
                if (w_div_rsp.done) begin
                    n_end   = (w_q_inc < w_stored_ext) ? w_q_inc : w_stored_ext;
                    n_state = S_SWP;
                end
            end
            S_SWP: begin
                if (r_sweep < r_end) begin
                    w_wr_en = 1'b1;
                    n_sweep = r_sweep + 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CMP: begin
                // Hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid       = 1'b1;
                    n_out.chunk_index = 8'(r_end_idx);
                    n_out.chunk_dirty = w_dirty;
                    n_out.chunk_hash  = r_hash;
                    n_out.final_chunk = r_end_last;
                    if (w_dirty) begin
                        w_wr_en         = 1'b1;
                        w_wr_addr       = r_end_idx;
                        w_wr_data.valid = 1'b1;
                        w_wr_data.hash  = r_hash;
                    end
                    n_hash  = FNV_BASIS;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Start with a clearing sweep over the whole table
            r_state     <= S_SWP;
            r_inv_en    <= 1'b1;
            r_pos       <= '0;
            r_size      <= '0;
            r_stored    <= '0;
            r_cib       <= '0;
            r_cidx      <= '0;
            r_sweep     <= '0;
            r_end       <= C_DIV_W'(MAX_CHUNKS);
            r_out_valid <= 1'b0;
            r_hash      <= FNV_BASIS;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_size      <= n_size;
            r_stored    <= n_stored;
            r_cib       <= n_cib;
            r_cidx      <= n_cidx;
            r_sweep     <= n_sweep;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
            r_hash      <= n_hash;
            if (i_cfg.valid) begin
                r_inv_en <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_end_idx  <= n_end_idx;
        r_end_last <= n_end_last;
        r_dvd2     <= n_dvd2;
        r_out      <= n_out;
    end

    a_stored_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= CNTW'(MAX_CHUNKS))
        else $error("stored chunk count beyond table depth");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_size)
        else $error("byte position past upload size");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_BDIV || r_state == S_IDIV1 || r_state == S_IDIV2))
        else $error("divider finished outside a divide step");

    a_cmp_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_IDLE || $past(r_state) == S_CMP))
        else $error("compare step entered without a chunk end");

    a_cmp_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP && w_wr_en) |=> r_out_valid)
        else $error("table updated without a result");

endmodule
